FILE: hw/rtl/apt_pkg.sv
package apt_pkg;

  // default table depth
  localparam int TABLE_ENTRIES_DEF = 128;

  localparam int MAC_W  = 48;
  localparam int TIME_W = 32;
  localparam int HITS_W = 16;
  localparam int SIG_W  = 8;
  localparam int CHAN_W = 8;
  localparam int SEC_W  = 3;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;
  localparam logic [SEC_W-1:0]  SEC_NOT_GIVEN = '0;

  // input word kinds (in_tuser)
  localparam logic KIND_OBSERVE = 1'b0;
  localparam logic KIND_CLEAR   = 1'b1;

  // stream widths
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  // one stored table entry
  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] seen;
    logic [HITS_W-1:0] hits;
    logic [SIG_W-1:0]  sig;
    logic [CHAN_W-1:0] chan;
    logic [SEC_W-1:0]  sec;
    logic              named;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/apt_ram.sv
module apt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/apt_ctrl.sv
module apt_ctrl
  import apt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  assign in_tready  = (state_r == ST_IDLE);
  assign cmd.load   = (state_r == ST_IDLE) && in_tvalid;
  assign cmd.scan   = (state_r == ST_SCAN);
  assign cmd.commit = (state_r == ST_FINISH) && sts.out_free;

  a_commit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> $past(state_r) == ST_SCAN || $past(state_r) == ST_FINISH)
    else $error("commit without a finished scan");

  a_load_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_SCAN)
    else $error("accepted word did not start a scan");

endmodule

FILE: hw/rtl/apt_dp.sv
module apt_dp
  import apt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tuser,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  // latched input word
  logic              clear_r;
  logic [MAC_W-1:0]  mac_r;
  logic [SIG_W-1:0]  sig_r;
  logic [CHAN_W-1:0] chan_r;
  logic [SEC_W-1:0]  sec_r;
  logic              named_r;
  logic [TIME_W-1:0] now_r;

  // occupancy and scan state
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     idx_r;
  logic              issue_end_r;
  logic              rd_vld_r;
  logic [IW-1:0]     rd_idx_r;
  logic              done_r;
  logic              hit_r;
  logic [IW-1:0]     hit_idx_r;
  ent_t              hit_ent_r;
  logic [IW-1:0]     old_idx_r;
  logic [TIME_W-1:0] old_ts_r;

  // result register
  logic                  out_valid_r;
  logic [6:0]            res_slot_r;
  logic                  res_known_r;
  logic                  res_recyc_r;
  logic [HITS_W-1:0]     res_hits_r;
  logic [7:0]            res_used_r;

  logic              re;
  ent_t              rd_ent;
  logic [ENT_W-1:0]  rd_data;
  logic              we;
  logic [IW-1:0]     waddr;
  ent_t              wdata;
  logic [CW-1:0]     cnt_m1;
  logic [IW-1:0]     last_idx;
  logic              full;
  logic              match;
  logic              take_old;
  logic [IW-1:0]     slot;
  logic              known;
  logic              recyc;
  logic [HITS_W-1:0] hits;
  logic [IW+6:0]     slot_ext;
  logic [CW+7:0]     used_ext;

  assign cnt_m1   = count_r - CW'(1);
  assign last_idx = cnt_m1[IW-1:0];
  assign full     = (count_r == CW'(TABLE_ENTRIES));
  assign rd_ent   = ent_t'(rd_data);
  assign match    = (rd_ent.mac == mac_r);
  assign take_old = (rd_idx_r == '0) || (rd_ent.seen < old_ts_r);

  assign re = cmd.scan && !done_r && !issue_end_r;

  apt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  // input latch: mac, signal, channel, security, name flag, time from bit 0 up
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      clear_r <= (in_tuser == KIND_CLEAR);
      mac_r   <= in_tdata[47:0];
      sig_r   <= in_tdata[55:48];
      chan_r  <= in_tdata[63:56];
      sec_r   <= in_tdata[66:64];
      named_r <= in_tdata[67];
      now_r   <= in_tdata[99:68];
    end
  end

  // scan: one read issued a cycle, compared in the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= 1'b0;
      rd_vld_r    <= 1'b0;
      issue_end_r <= 1'b0;
      hit_r       <= 1'b0;
    end else if (cmd.load) begin
      done_r      <= (in_tuser == KIND_CLEAR) || (count_r == '0);
      rd_vld_r    <= 1'b0;
      issue_end_r <= 1'b0;
      hit_r       <= 1'b0;
      idx_r       <= '0;
      old_idx_r   <= '0;
    end else begin
      rd_vld_r <= re;
      rd_idx_r <= idx_r;
      if (re) begin
        if (idx_r == last_idx) issue_end_r <= 1'b1;
        else                   idx_r <= idx_r + IW'(1);
      end
      if (rd_vld_r && !done_r) begin
        if (match) begin
          hit_r     <= 1'b1;
          hit_idx_r <= rd_idx_r;
          hit_ent_r <= rd_ent;
          done_r    <= 1'b1;
        end else begin
          if (take_old) begin
            old_idx_r <= rd_idx_r;
            old_ts_r  <= rd_ent.seen;
          end
          if (rd_idx_r == last_idx) done_r <= 1'b1;
        end
      end
    end
  end

  // entry update and result
  always_comb begin
    wdata     = '0;
    wdata.mac = mac_r;
    wdata.seen  = now_r;
    wdata.sig   = sig_r;
    wdata.chan  = chan_r;
    wdata.sec   = sec_r;
    wdata.named = named_r;
    wdata.hits  = HITS_W'(1);
    we        = 1'b0;
    waddr     = count_r[IW-1:0];
    count_nxt = count_r;
    slot      = '0;
    known     = 1'b0;
    recyc     = 1'b0;
    hits      = '0;
    if (clear_r) begin
      count_nxt = '0;
    end else if (hit_r) begin
      we          = 1'b1;
      waddr       = hit_idx_r;
      wdata.hits  = (hit_ent_r.hits == HITS_MAX) ? HITS_MAX : hit_ent_r.hits + HITS_W'(1);
      wdata.sec   = (sec_r == SEC_NOT_GIVEN) ? hit_ent_r.sec : sec_r;
      wdata.named = named_r | hit_ent_r.named;
      slot        = hit_idx_r;
      known       = 1'b1;
      hits        = wdata.hits;
    end else begin
      we    = 1'b1;
      hits  = HITS_W'(1);
      if (full) begin
        waddr = old_idx_r;
        recyc = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
      end
      slot = waddr;
    end
    we = we && cmd.commit;
  end

  assign slot_ext = {7'd0, slot};
  assign used_ext = {8'd0, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
        res_slot_r  <= slot_ext[6:0];
        res_known_r <= known;
        res_recyc_r <= recyc;
        res_hits_r  <= hits;
        res_used_r  <= used_ext[7:0];
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.scan_done = done_r;
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_used_r, res_hits_r, res_slot_r};
  assign out_tuser  = {res_recyc_r, res_known_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_ENTRIES))
    else $error("occupancy beyond table depth");

  a_new_entry_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !clear_r && !hit_r && !full |=> count_r == $past(count_r) + CW'(1))
    else $error("new entry did not grow occupancy");

  a_known_has_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_known_r |-> res_hits_r != '0 && !res_recyc_r)
    else $error("hit result with zero count or eviction");

  a_recycle_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && recyc |-> full)
    else $error("eviction with free slots left");

endmodule

FILE: hw/rtl/access_point_tracking_table.sv
// Up to TABLE_ENTRIES occupied slots are read one per cycle from the entry RAM and
// compared with the word's mac; the scan ends early on a hit, and a clear or an empty
// table reads no slot. One word at a time: a new word is taken only after the last
// word's result is committed; the scan rate is set by the single RAM read port.
// Reset (rst_n low, synchronous): table empty, no result pending; entry RAM is not
// cleared, as only occupied slots are ever read.
module access_point_tracking_table
  import apt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [47:0] mac_address, [55:48] signal_dbm, [63:56] channel_number,
  // [66:64] security_class, [67] name_present, [99:68] time_ms, [103:100] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] kind
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [6:0] slot_index, [22:7] hit_total, [30:23] entries_used, [31] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] was_known, [1] was_recycled
  output logic [OUT_USER_W-1:0] out_tuser
);

  cmd_t cmd;
  sts_t sts;

  apt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  apt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
